@@ rtl/core/descriptor_table_refcount_assert.svh @@
// Assertion macros for the descriptor table. Clock clk_i, reset rst_ni.
`ifndef DESCRIPTOR_TABLE_REFCOUNT_ASSERT_SVH
`define DESCRIPTOR_TABLE_REFCOUNT_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define DTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must be followed by another in the next cycle.
`define DTR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define DTR_ASSERT(lbl, prop, msg)
`define DTR_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/core/dtr_pkg.sv @@
package dtr_pkg;

  localparam int TableSizeDef = 8;
  localparam int MapW         = 7;   // 0 = closed, else description + 1
  localparam int CntW         = 7;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [1:0] {
    ReqOpen   = 2'd0,
    ReqClose  = 2'd1,
    ReqShare  = 2'd2,
    ReqLookup = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StLimit    = 2'd1,
    StBadFd    = 2'd2,
    StOpenFail = 2'd3
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic signed [7:0] source_fd;
    logic signed [7:0] target_fd;
    logic              open_failed;
  } req_word_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] result_fd;
    logic [5:0] description;
  } rsp_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_src;
    logic rd_tgt;
    logic do_open;
    logic do_drop;
    logic do_add;
    logic set_rsp;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    logic src_ok;
    logic share_go;
    logic rsp_busy;
  } stat_t;

endpackage

@@ rtl/core/dtr_datapath.sv @@
module dtr_datapath #(
  parameter int TableSize = dtr_pkg::TableSizeDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtr_pkg::req_word_t in_word_i,
  input  dtr_pkg::cmd_t     cmd_i,
  output dtr_pkg::stat_t    stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output dtr_pkg::rsp_word_t out_word_o
);

  localparam int IdxW = $clog2(TableSize);
  localparam logic [7:0] SizeU8 = 8'(TableSize);
  localparam logic [dtr_pkg::MapW-1:0] SizeMap = dtr_pkg::MapW'(TableSize);

  // tables
  logic [dtr_pkg::MapW-1:0] map_q [TableSize];
  logic [dtr_pkg::CntW-1:0] cnt_q [TableSize];

  // request word
  dtr_pkg::req_e     req_q;
  logic signed [7:0] src_q, tgt_q;
  logic              ofail_q;

  // search results, latched at load
  logic [IdxW-1:0] free_idx_q, zero_idx_q;
  logic            free_any_q, zero_any_q;

  // source / target lookups
  logic              src_ok_q;
  logic [IdxW-1:0]   src_slot_q;
  logic              tgt_ok_q, tgt_used_q;
  dtr_pkg::status_e  tgt_err_q;
  logic [IdxW-1:0]   tgt_idx_q, tslot_q;

  logic               out_valid_q;
  dtr_pkg::rsp_word_t out_word_q;

  function automatic logic fd_in_range(logic signed [7:0] fd);
    return !fd[7] && ($unsigned(fd) < SizeU8);
  endfunction

  // lowest free descriptor and lowest unreferenced description
  logic [IdxW-1:0] free_idx, zero_idx;
  logic            free_any, zero_any;
  always_comb begin
    free_idx = '0;
    zero_idx = '0;
    free_any = 1'b0;
    zero_any = 1'b0;
    for (int i = TableSize - 1; i >= 0; i--) begin
      if (map_q[i] == '0) begin
        free_idx = IdxW'(i);
        free_any = 1'b1;
      end
      if (cnt_q[i] == '0) begin
        zero_idx = IdxW'(i);
        zero_any = 1'b1;
      end
    end
  end

  // target resolution
  logic            tgt_m1, tgt_ok, same;
  logic [IdxW-1:0] tgt_eff;
  assign tgt_m1  = (tgt_q == -8'sd1);
  assign tgt_eff = tgt_m1 ? free_idx : tgt_q[IdxW-1:0];
  assign tgt_ok  = tgt_m1 ? free_any : fd_in_range(tgt_q);
  assign same    = (tgt_eff == src_q[IdxW-1:0]);

  // single map read port, source or target
  logic                     src_range, rd_in, entry_ok;
  logic [IdxW-1:0]          rd_idx, entry_slot;
  logic [dtr_pkg::MapW-1:0] map_rd;
  assign src_range  = fd_in_range(src_q);
  assign rd_idx     = cmd_i.rd_tgt ? tgt_eff : src_q[IdxW-1:0];
  assign rd_in      = cmd_i.rd_tgt ? tgt_ok : src_range;
  assign map_rd     = rd_in ? map_q[rd_idx] : '0;
  assign entry_ok   = (map_rd != '0) && (map_rd <= SizeMap);
  assign entry_slot = IdxW'(map_rd - dtr_pkg::MapW'(1));

  assign stat_o.req      = req_q;
  assign stat_o.src_ok   = src_range && entry_ok;
  assign stat_o.share_go = tgt_ok && !same;
  assign stat_o.rsp_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= in_word_i.req_type;
      src_q      <= in_word_i.source_fd;
      tgt_q      <= in_word_i.target_fd;
      ofail_q    <= in_word_i.open_failed;
      free_idx_q <= free_idx;
      free_any_q <= free_any;
      zero_idx_q <= zero_idx;
      zero_any_q <= zero_any;
    end
    if (cmd_i.rd_src) begin
      src_ok_q   <= src_range && entry_ok;
      src_slot_q <= entry_slot;
    end
    if (cmd_i.rd_tgt) begin
      tgt_ok_q   <= tgt_ok;
      tgt_err_q  <= tgt_m1 ? dtr_pkg::StLimit : dtr_pkg::StBadFd;
      tgt_idx_q  <= tgt_eff;
      tgt_used_q <= entry_ok;
      tslot_q    <= entry_slot;
    end
  end

  // table updates
  logic [IdxW-1:0] drop_slot;
  logic            drop_en;
  assign drop_slot = (req_q == dtr_pkg::ReqClose) ? src_slot_q : tslot_q;
  assign drop_en   = (req_q == dtr_pkg::ReqClose) || tgt_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableSize; i++) begin
        map_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.do_open && free_any_q && zero_any_q && !ofail_q) begin
        cnt_q[zero_idx_q] <= dtr_pkg::CntW'(1);
        map_q[free_idx_q] <= dtr_pkg::MapW'(zero_idx_q) + dtr_pkg::MapW'(1);
      end
      if (cmd_i.do_drop) begin
        if (drop_en && cnt_q[drop_slot] != '0) begin
          cnt_q[drop_slot] <= cnt_q[drop_slot] - dtr_pkg::CntW'(1);
        end
        if (req_q == dtr_pkg::ReqClose) begin
          map_q[src_q[IdxW-1:0]] <= '0;
        end
      end
      if (cmd_i.do_add) begin
        map_q[tgt_idx_q] <= dtr_pkg::MapW'(src_slot_q) + dtr_pkg::MapW'(1);
        if (cnt_q[src_slot_q] != dtr_pkg::CntMax) begin
          cnt_q[src_slot_q] <= cnt_q[src_slot_q] + dtr_pkg::CntW'(1);
        end
      end
    end
  end

  // result word
  dtr_pkg::rsp_word_t rsp_d;
  always_comb begin
    rsp_d = '0;
    case (req_q)
      dtr_pkg::ReqOpen: begin
        if (!(free_any_q && zero_any_q)) begin
          rsp_d.status = dtr_pkg::StLimit;
        end else if (ofail_q) begin
          rsp_d.status = dtr_pkg::StOpenFail;
        end else begin
          rsp_d.status      = dtr_pkg::StOk;
          rsp_d.result_fd   = 7'(free_idx_q);
          rsp_d.description = 6'(zero_idx_q);
        end
      end
      dtr_pkg::ReqClose: begin
        rsp_d.status = src_ok_q ? dtr_pkg::StOk : dtr_pkg::StBadFd;
      end
      dtr_pkg::ReqShare: begin
        if (!src_ok_q) begin
          rsp_d.status = dtr_pkg::StBadFd;
        end else if (!tgt_ok_q) begin
          rsp_d.status = tgt_err_q;
        end else begin
          rsp_d.status    = dtr_pkg::StOk;
          rsp_d.result_fd = 7'(tgt_idx_q);
        end
      end
      dtr_pkg::ReqLookup: begin
        if (!src_ok_q) begin
          rsp_d.status = dtr_pkg::StBadFd;
        end else begin
          rsp_d.status      = dtr_pkg::StOk;
          rsp_d.description = 6'(src_slot_q);
        end
      end
      default: rsp_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.set_rsp) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_rsp) begin
      out_word_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/core/dtr_ctrl.sv @@
module dtr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  dtr_pkg::req_e  req_type_i,
  output logic           in_stall_o,
  input  dtr_pkg::stat_t stat_i,
  output dtr_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StSrc  = 7'b0000010,
    StTgt  = 7'b0000100,
    StOpen = 7'b0001000,
    StDrop = 7'b0010000,
    StAdd  = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_type_i == dtr_pkg::ReqOpen) ? StOpen : StSrc;
        end
      end
      StSrc: begin
        cmd_o.rd_src = 1'b1;
        state_d      = StFin;
        if (stat_i.src_ok) begin
          if (stat_i.req == dtr_pkg::ReqClose) begin
            state_d = StDrop;
          end else if (stat_i.req == dtr_pkg::ReqShare) begin
            state_d = StTgt;
          end
        end
      end
      StTgt: begin
        cmd_o.rd_tgt = 1'b1;
        state_d      = stat_i.share_go ? StDrop : StFin;
      end
      StOpen: begin
        cmd_o.do_open = 1'b1;
        state_d       = StFin;
      end
      StDrop: begin
        cmd_o.do_drop = 1'b1;
        state_d       = (stat_i.req == dtr_pkg::ReqShare) ? StAdd : StFin;
      end
      StAdd: begin
        cmd_o.do_add = 1'b1;
        state_d      = StFin;
      end
      StFin: begin
        // wait for the output register to free up
        if (!stat_i.rsp_busy) begin
          cmd_o.set_rsp = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

@@ rtl/core/descriptor_table_refcount.sv @@
// Channel  Dir  Handshake              Word
// in       in   in_valid_i/in_stall_o  req_word_t: req_type, source_fd, target_fd, open_failed
// out      out  out_valid_o/out_stall_i rsp_word_t: status, result_fd, description
//
// One request at a time, walked by a sequencer over one shared map read port
// and one count read-modify-write per cycle: open steps load, open, finish; lookup steps
// load, source read, finish; close adds a drop; share at most source read, target read, drop, add, finish.
// Reset (rst_ni, async, low) clears both tables at once: every descriptor closed.
// A result sits in the output register; the next request is taken while it
// waits, and the finish step holds only if the previous result is still stalled.

`include "descriptor_table_refcount_assert.svh"

module descriptor_table_refcount #(
  parameter int TableSize = dtr_pkg::TableSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtr_pkg::req_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtr_pkg::rsp_word_t out_word_o
);

  dtr_pkg::cmd_t  cmd;
  dtr_pkg::stat_t stat;

  // sequencer: one step per cycle but for a stalled finish, branching on the source/target checks
  dtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_word_i.req_type),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, lowest-free searches, lookup registers and the output register
  dtr_datapath #(
    .TableSize (TableSize)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // a taken word always starts a walk, with the input stalled
  `DTR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept not followed by busy")
  // returned indexes stay inside the table
  `DTR_ASSERT(a_rsp_in_range, !out_valid_o || (out_word_o.description < TableSize && out_word_o.result_fd < TableSize), "result index out of table")
  // a failed request returns zero fields
  `DTR_ASSERT(a_fail_zero, !out_valid_o || out_word_o.status == dtr_pkg::StOk || (out_word_o.result_fd == '0 && out_word_o.description == '0), "failed result carries data")

endmodule
